// ===== rtl/core/bpc_pkg.sv =====
// shared types, constants and helpers for the barometric compensation datapath
package bpc_pkg;

  localparam int CalW   = 32;
  localparam int OssW   = 2;
  localparam int IdxW   = 3;
  localparam int DivW   = 32;
  localparam int TempW  = 16;
  localparam int UpW    = 24;
  localparam int SideAW = DivW + UpW + 2;
  localparam int SideBW = TempW + 2;

  // configuration register indexes
  localparam logic [IdxW-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [IdxW-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [IdxW-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [IdxW-1:0] REG_B1_B2   = 3'd3;
  localparam logic [IdxW-1:0] REG_MC_MD   = 3'd4;
  localparam logic [IdxW-1:0] REG_OSS     = 3'd5;

  // compensation constants
  localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
  localparam logic signed [31:0] X3_OFFSET  = 32'sd32768;
  localparam logic [31:0]        B7_SCALE   = 32'd50000;
  localparam logic signed [31:0] P_SQ_COEF  = 32'sd3038;
  localparam logic signed [31:0] P_LIN_COEF = -32'sd7357;
  localparam logic signed [31:0] P_OFFSET   = 32'sd3791;

  // unpacked calibration coefficients
  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic [OssW-1:0]    oss;
  } cal_t;

  // signed divide by two to the k, truncating toward zero
  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] a,
                                                 input int unsigned k);
    logic signed [31:0] bias;
    bias = a[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
    return (a + bias) >>> k;
  endfunction

endpackage

// ===== rtl/core/bpc_div.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage
module bpc_div #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  in_num,
  input  logic [W-1:0]  in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [W-1:0]  out_quo,
  output logic [SW-1:0] out_side
);

  logic          v_r    [W];
  logic [W-1:0]  rem_r  [W];
  logic [W-1:0]  dq_r   [W];
  logic [W-1:0]  den_r  [W];
  logic [SW-1:0] side_r [W];

  genvar i;
  generate
    for (i = 0; i < W; i++) begin : g_stage
      logic          v_in;
      logic [W-1:0]  rem_in;
      logic [W-1:0]  dq_in;
      logic [W-1:0]  den_in;
      logic [SW-1:0] side_in;
      logic [W:0]    shifted;
      logic [W:0]    diff;
      logic          ge;

      if (i == 0) begin : g_first
        assign v_in    = in_valid;
        assign rem_in  = '0;
        assign dq_in   = in_num;
        assign den_in  = in_den;
        assign side_in = in_side;
      end else begin : g_next
        assign v_in    = v_r[i-1];
        assign rem_in  = rem_r[i-1];
        assign dq_in   = dq_r[i-1];
        assign den_in  = den_r[i-1];
        assign side_in = side_r[i-1];
      end

      // trial subtract of the divisor
      assign shifted = {rem_in, dq_in[W-1]};
      assign diff    = shifted - {1'b0, den_in};
      assign ge      = ~diff[W];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (en) begin
          v_r[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i]  <= ge ? diff[W-1:0] : shifted[W-1:0];
          dq_r[i]   <= {dq_in[W-2:0], ge};
          den_r[i]  <= den_in;
          side_r[i] <= side_in;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[W-1];
  assign out_quo   = dq_r[W-1];
  assign out_side  = side_r[W-1];

endmodule

// ===== rtl/core/bpc_front.sv =====
// temperature front end: stages up to the operands of the temperature divide
module bpc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  bpc_pkg::cal_t             cal,
  input  logic                      in_valid,
  input  logic [15:0]               raw_t,
  input  logic [23:0]               raw_p,
  output logic                      a_valid,
  output logic [bpc_pkg::DivW-1:0]  a_num,
  output logic [bpc_pkg::DivW-1:0]  a_den,
  output logic [bpc_pkg::SideAW-1:0] a_side
);

  logic                      s1_v_r, s2_v_r, s3_v_r;
  logic signed [31:0]        s1_prod_r, s1_prod_nxt;
  logic [bpc_pkg::UpW-1:0]   s1_up_r, s1_up_nxt;
  logic signed [31:0]        s2_x1_r, s2_x1_nxt;
  logic signed [31:0]        s2_t_r, s2_t_nxt;
  logic [bpc_pkg::UpW-1:0]   s2_up_r;
  logic [31:0]               s3_nmag_r, s3_nmag_nxt;
  logic [31:0]               s3_tmag_r, s3_tmag_nxt;
  logic signed [31:0]        s3_x1_r;
  logic [bpc_pkg::UpW-1:0]   s3_up_r;
  logic                      s3_tzero_r, s3_tzero_nxt;
  logic                      s3_qneg_r, s3_qneg_nxt;
  logic signed [16:0]        d17;
  logic signed [31:0]        num;

  // stage 1: (ut - ac6) * ac5 and oversampling shift
  always_comb begin
    d17         = $signed({1'b0, raw_t}) - $signed({1'b0, cal.ac6});
    s1_prod_nxt = 32'(d17) * $signed({16'h0, cal.ac5});
    s1_up_nxt   = raw_p >> (4'd8 - {2'b00, cal.oss});
  end

  // stage 2: x1 and the divisor x1 + md
  always_comb begin
    s2_x1_nxt = bpc_pkg::sdiv_p2(s1_prod_r, 15);
    s2_t_nxt  = s2_x1_nxt + 32'(cal.md);
  end

  // stage 3: magnitudes and quotient sign
  always_comb begin
    num          = 32'(cal.mc) <<< 11;
    s3_nmag_nxt  = num[31] ? 32'(-num) : 32'(num);
    s3_tmag_nxt  = s2_t_r[31] ? 32'(-s2_t_r) : 32'(s2_t_r);
    s3_tzero_nxt = (s2_t_r == 32'sd0);
    s3_qneg_nxt  = num[31] ^ s2_t_r[31];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_r  <= s1_prod_nxt;
      s1_up_r    <= s1_up_nxt;
      s2_x1_r    <= s2_x1_nxt;
      s2_t_r     <= s2_t_nxt;
      s2_up_r    <= s1_up_r;
      s3_nmag_r  <= s3_nmag_nxt;
      s3_tmag_r  <= s3_tmag_nxt;
      s3_x1_r    <= s2_x1_r;
      s3_up_r    <= s2_up_r;
      s3_tzero_r <= s3_tzero_nxt;
      s3_qneg_r  <= s3_qneg_nxt;
    end
  end

  assign a_valid = s3_v_r;
  assign a_num   = s3_nmag_r;
  assign a_den   = s3_tmag_r;
  assign a_side  = {s3_x1_r, s3_up_r, s3_tzero_r, s3_qneg_r};

endmodule

// ===== rtl/core/bpc_coef.sv =====
// temperature result and pressure coefficients b3, b4, b7
module bpc_coef (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  bpc_pkg::cal_t              cal,
  input  logic                       a_valid,
  input  logic [bpc_pkg::DivW-1:0]   a_quo,
  input  logic [bpc_pkg::SideAW-1:0] a_side,
  output logic                       b_valid,
  output logic [bpc_pkg::DivW-1:0]   b_num,
  output logic [bpc_pkg::DivW-1:0]   b_den,
  output logic [bpc_pkg::SideBW-1:0] b_side
);

  logic [6:0]              v_r;
  logic signed [31:0]      a_x1;
  logic [bpc_pkg::UpW-1:0] a_up;
  logic                    a_tzero, a_qneg;
  logic signed [31:0]      x2, b5;

  logic signed [31:0] p1_b6_r;
  logic [15:0]        p1_tout_r [7];
  logic               err_r     [7];
  logic [bpc_pkg::UpW-1:0] up_r [6];

  logic signed [31:0] p2_sq_r, p2_m2_r, p2_m3_r;
  logic signed [31:0] p3_sq_r, p3_x2a_r, p3_x1c_r;
  logic signed [31:0] p4_mb2_r, p4_mb1_r, p4_x2a_r, p4_x1c_r;
  logic signed [31:0] p5_b3pre_r, p5_x3b_r, p5_x3b_nxt, p5_b3pre_nxt;
  logic signed [31:0] p6_b3_r;
  logic [31:0]        p6_b4_r, p6_b4m;
  logic [31:0]        p7_b7_r, p7_b4_r;
  logic signed [31:0] x3;

  assign {a_x1, a_up, a_tzero, a_qneg} = a_side;

  // stage 1: b5 and b6
  always_comb begin
    x2 = a_qneg ? $signed(-a_quo) : $signed(a_quo);
    b5 = a_x1 + x2;
  end

  // stage 5: b3 before rounding and x3 + 32768
  always_comb begin
    x3           = bpc_pkg::sdiv_p2(p4_mb2_r, 11) + p4_x2a_r;
    p5_b3pre_nxt = ((32'(cal.ac1) <<< 2) + x3) <<< cal.oss;
    p5_x3b_nxt   = bpc_pkg::sdiv_p2(p4_x1c_r + bpc_pkg::sdiv_p2(p4_mb1_r, 16) + 32'sd2, 2)
                   + bpc_pkg::X3_OFFSET;
  end

  // stage 6: ac4 product for b4
  assign p6_b4m = {16'h0, cal.ac4} * $unsigned(p5_x3b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], a_valid};
    end
  end

  // side info travels along the stages
  always_ff @(posedge clk) begin
    if (en) begin
      p1_tout_r[0] <= 16'(bpc_pkg::sdiv_p2(b5 + 32'sd8, 4));
      err_r[0]     <= a_tzero;
      up_r[0]      <= a_up;
      for (int k = 1; k < 7; k++) begin
        p1_tout_r[k] <= p1_tout_r[k-1];
      end
      for (int k = 1; k < 6; k++) begin
        err_r[k] <= err_r[k-1];
        up_r[k]  <= up_r[k-1];
      end
      err_r[6] <= err_r[5] | (p6_b4_r == 32'd0);
    end
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      p1_b6_r    <= b5 - bpc_pkg::B6_OFFSET;
      p2_sq_r    <= p1_b6_r * p1_b6_r;
      p2_m2_r    <= 32'(cal.ac2) * p1_b6_r;
      p2_m3_r    <= 32'(cal.ac3) * p1_b6_r;
      p3_sq_r    <= bpc_pkg::sdiv_p2(p2_sq_r, 12);
      p3_x2a_r   <= bpc_pkg::sdiv_p2(p2_m2_r, 11);
      p3_x1c_r   <= bpc_pkg::sdiv_p2(p2_m3_r, 13);
      p4_mb2_r   <= 32'(cal.b2) * p3_sq_r;
      p4_mb1_r   <= 32'(cal.b1) * p3_sq_r;
      p4_x2a_r   <= p3_x2a_r;
      p4_x1c_r   <= p3_x1c_r;
      p5_b3pre_r <= p5_b3pre_nxt;
      p5_x3b_r   <= p5_x3b_nxt;
      p6_b3_r    <= bpc_pkg::sdiv_p2(p5_b3pre_r + 32'sd2, 2);
      p6_b4_r    <= p6_b4m >> 15;
      p7_b7_r    <= ({8'h0, up_r[5]} - $unsigned(p6_b3_r)) * (bpc_pkg::B7_SCALE >> cal.oss);
      p7_b4_r    <= p6_b4_r;
    end
  end

  // dividend doubled before or after the divide
  assign b_valid = v_r[6];
  assign b_num   = p7_b7_r[31] ? p7_b7_r : {p7_b7_r[30:0], 1'b0};
  assign b_den   = p7_b4_r;
  assign b_side  = {p1_tout_r[6], err_r[6], p7_b7_r[31]};

endmodule

// ===== rtl/core/bpc_tail.sv =====
// final pressure correction and result register
module bpc_tail (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       b_valid,
  input  logic [bpc_pkg::DivW-1:0]   b_quo,
  input  logic [bpc_pkg::SideBW-1:0] b_side,
  output logic                       o_valid,
  output logic signed [15:0]         o_temp,
  output logic [31:0]                o_press,
  output logic                       o_err
);

  logic [4:0]         v_r;
  logic [15:0]        b_tout;
  logic               b_err, b_shift;
  logic [15:0]        tout_r [4];
  logic               err_r  [4];
  logic [31:0]        p_r    [4];
  logic signed [31:0] q2_xx_r, q2_pm_r, q3_x1_r, q3_x2_r, q4_s_r, corr;
  logic [23:0]        pd;
  logic signed [15:0] o_temp_r;
  logic [31:0]        o_press_r;
  logic               o_err_r;

  assign {b_tout, b_err, b_shift} = b_side;
  assign pd   = p_r[0][31:8];
  assign corr = bpc_pkg::sdiv_p2(q4_s_r, 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], b_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]    <= b_shift ? {b_quo[30:0], 1'b0} : b_quo;
      tout_r[0] <= b_tout;
      err_r[0]  <= b_err;
      for (int k = 1; k < 4; k++) begin
        p_r[k]    <= p_r[k-1];
        tout_r[k] <= tout_r[k-1];
        err_r[k]  <= err_r[k-1];
      end
      q2_xx_r   <= $signed({8'h0, pd} * {8'h0, pd});
      q2_pm_r   <= $signed(p_r[0]) * bpc_pkg::P_LIN_COEF;
      q3_x1_r   <= q2_xx_r * bpc_pkg::P_SQ_COEF;
      q3_x2_r   <= bpc_pkg::sdiv_p2(q2_pm_r, 16);
      q4_s_r    <= bpc_pkg::sdiv_p2(q3_x1_r, 16) + q3_x2_r + bpc_pkg::P_OFFSET;
      // result register, zeroed on a divide error
      o_temp_r  <= err_r[3] ? 16'sd0 : $signed(tout_r[3]);
      o_press_r <= err_r[3] ? 32'd0 : p_r[3] + $unsigned(corr);
      o_err_r   <= err_r[3];
    end
  end

  assign o_valid = v_r[4];
  assign o_temp  = o_temp_r;
  assign o_press = o_press_r;
  assign o_err   = o_err_r;

endmodule

// ===== rtl/core/barometric_pressure_compensation_top.sv =====
// top level of the barometric pressure and temperature compensation pipeline
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_stall, in_raw_temperature, ...     | in
//  result  | out_valid, out_stall, out_temperature_deci_c,...| out
//  config  | cfg_we, cfg_index, cfg_data                      | in
//
// one item enters per cycle while in_stall is low; the pipeline holds two 32-stage dividers
// reset clears all valid bits and the calibration registers
// a stalled result freezes the whole pipeline, so nothing is lost or repeated
module barometric_pressure_compensation_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [15:0]              in_raw_temperature,
  input  logic [23:0]              in_raw_pressure_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       out_temperature_deci_c,
  output logic [31:0]              out_pressure_pa,
  output logic                     out_divide_error,
  input  logic                     cfg_we,
  input  logic [bpc_pkg::IdxW-1:0] cfg_index,
  input  logic [bpc_pkg::CalW-1:0] cfg_data
);

  logic [31:0]              ac1_ac2_r, ac3_ac4_r, ac5_ac6_r, b1_b2_r, mc_md_r;
  logic [bpc_pkg::OssW-1:0] oss_r;
  bpc_pkg::cal_t            cal;
  logic                     en;

  logic                       a_valid, a_qv, b_valid, b_qv;
  logic [bpc_pkg::DivW-1:0]   a_num, a_den, a_quo, b_num, b_den, b_quo;
  logic [bpc_pkg::SideAW-1:0] a_side, a_qside;
  logic [bpc_pkg::SideBW-1:0] b_side, b_qside;

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_ac2_r <= '0;
      ac3_ac4_r <= '0;
      ac5_ac6_r <= '0;
      b1_b2_r   <= '0;
      mc_md_r   <= '0;
      oss_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::REG_AC1_AC2: ac1_ac2_r <= cfg_data;
        bpc_pkg::REG_AC3_AC4: ac3_ac4_r <= cfg_data;
        bpc_pkg::REG_AC5_AC6: ac5_ac6_r <= cfg_data;
        bpc_pkg::REG_B1_B2:   b1_b2_r   <= cfg_data;
        bpc_pkg::REG_MC_MD:   mc_md_r   <= cfg_data;
        bpc_pkg::REG_OSS:     oss_r     <= cfg_data[bpc_pkg::OssW-1:0];
        default: ;
      endcase
    end
  end

  assign cal = '{ac1: ac1_ac2_r[31:16], ac2: ac1_ac2_r[15:0],
                 ac3: ac3_ac4_r[31:16], ac4: ac3_ac4_r[15:0],
                 ac5: ac5_ac6_r[31:16], ac6: ac5_ac6_r[15:0],
                 b1:  b1_b2_r[31:16],   b2:  b1_b2_r[15:0],
                 mc:  mc_md_r[31:16],   md:  mc_md_r[15:0],
                 oss: oss_r};

  // pipeline advances unless a finished item is held
  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  bpc_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .cal(cal),
    .in_valid(in_valid), .raw_t(in_raw_temperature), .raw_p(in_raw_pressure_word),
    .a_valid(a_valid), .a_num(a_num), .a_den(a_den), .a_side(a_side)
  );

  bpc_div #(.W(bpc_pkg::DivW), .SW(bpc_pkg::SideAW)) u_div_t (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(a_valid), .in_num(a_num), .in_den(a_den), .in_side(a_side),
    .out_valid(a_qv), .out_quo(a_quo), .out_side(a_qside)
  );

  bpc_coef u_coef (
    .clk(clk), .rst_n(rst_n), .en(en), .cal(cal),
    .a_valid(a_qv), .a_quo(a_quo), .a_side(a_qside),
    .b_valid(b_valid), .b_num(b_num), .b_den(b_den), .b_side(b_side)
  );

  bpc_div #(.W(bpc_pkg::DivW), .SW(bpc_pkg::SideBW)) u_div_p (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(b_valid), .in_num(b_num), .in_den(b_den), .in_side(b_side),
    .out_valid(b_qv), .out_quo(b_quo), .out_side(b_qside)
  );

  bpc_tail u_tail (
    .clk(clk), .rst_n(rst_n), .en(en),
    .b_valid(b_qv), .b_quo(b_quo), .b_side(b_qside),
    .o_valid(out_valid), .o_temp(out_temperature_deci_c),
    .o_press(out_pressure_pa), .o_err(out_divide_error)
  );

endmodule

// ===== bench/barometric_pressure_compensation_top_test.sv =====
// testbench for the barometric pressure and temperature compensation pipeline
`timescale 1ns / 100ps

module barometric_pressure_compensation_top_test;

  // one compensated reading
  typedef struct {
    logic signed [15:0] temp;
    logic [31:0]        pres;
    logic               derr;
  } reading_t;

  // calibration image and compensation arithmetic
  class comp_scoreboard;
    logic [31:0] regs [6];
    reading_t    pending [$];
    int          errors;
    int          checked;
    int          div_errors;

    function void clear_cal();
      foreach (regs[i]) regs[i] = '0;
    endfunction

    function void write_reg(int idx, logic [31:0] v);
      if (idx == int'(bpc_pkg::REG_OSS)) regs[idx] = {30'd0, v[1:0]};
      else if (idx < 6) regs[idx] = v;
    endfunction

    // signed 32-bit quotient truncating toward zero, with wrap
    function logic signed [31:0] sdiv(logic signed [31:0] a, logic signed [31:0] b);
      longint q;
      q = longint'(a) / longint'(b);
      return q[31:0];
    endfunction

    function reading_t compensate(logic [15:0] ut_raw, logic [23:0] up_raw);
      reading_t r;
      logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, ac5, ac6, ut;
      logic signed [31:0] x1, x2, x3, b3, b5, b6, t, sq, corr, tq;
      logic [31:0] ac4, b4, b7, p, up;
      logic [1:0] oss;
      ac1 = 32'(signed'(regs[bpc_pkg::REG_AC1_AC2][31:16]));
      ac2 = 32'(signed'(regs[bpc_pkg::REG_AC1_AC2][15:0]));
      ac3 = 32'(signed'(regs[bpc_pkg::REG_AC3_AC4][31:16]));
      ac4 = {16'd0, regs[bpc_pkg::REG_AC3_AC4][15:0]};
      ac5 = {16'd0, regs[bpc_pkg::REG_AC5_AC6][31:16]};
      ac6 = {16'd0, regs[bpc_pkg::REG_AC5_AC6][15:0]};
      b1 = 32'(signed'(regs[bpc_pkg::REG_B1_B2][31:16]));
      b2 = 32'(signed'(regs[bpc_pkg::REG_B1_B2][15:0]));
      mc = 32'(signed'(regs[bpc_pkg::REG_MC_MD][31:16]));
      md = 32'(signed'(regs[bpc_pkg::REG_MC_MD][15:0]));
      oss = regs[bpc_pkg::REG_OSS][1:0];
      ut = {16'd0, ut_raw};
      up = {8'd0, up_raw} >> (8 - oss);
      r.temp = 0; r.pres = 0; r.derr = 1;
      // temperature path
      x1 = sdiv((ut - ac6) * ac5, 32768);
      t = x1 + md;
      if (t == 0) return r;
      x2 = sdiv(mc * 2048, t);
      b5 = x1 + x2;
      tq = sdiv(b5 + 8, 16);
      // pressure path
      b6 = b5 - 4000;
      sq = sdiv(b6 * b6, 4096);
      x1 = sdiv(b2 * sq, 2048);
      x2 = sdiv(ac2 * b6, 2048);
      x3 = x1 + x2;
      b3 = (ac1 * 4 + x3) * (32'sd1 <<< oss);
      b3 = sdiv(b3 + 2, 4);
      x1 = sdiv(ac3 * b6, 8192);
      x2 = sdiv(b1 * sq, 65536);
      x3 = sdiv(x1 + x2 + 2, 4) + 32768;
      b4 = (ac4 * x3) / 32'd32768;
      if (b4 == 0) return r;
      b7 = (up - b3) * (32'd50000 >> oss);
      if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
      else p = (b7 / b4) << 1;
      x1 = p / 256;
      x1 = x1 * x1;
      x1 = sdiv(x1 * 3038, 65536);
      x2 = sdiv(signed'(p) * -32'sd7357, 65536);
      corr = sdiv(x1 + x2 + 3791, 16);
      r.temp = tq[15:0];
      r.pres = p + corr;
      r.derr = 0;
      return r;
    endfunction

    function void note_input(logic [15:0] ut, logic [23:0] up);
      pending.push_back(compensate(ut, up));
    endfunction

    function void check_result(logic signed [15:0] t, logic [31:0] p, logic d);
      reading_t e;
      if (pending.size() == 0) begin
        $error("unexpected result temp=%0d pres=%0d err=%0b", t, p, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (d) div_errors++;
      if (t !== e.temp) begin
        $error("temperature_deci_c expected %0d actual %0d", e.temp, t);
        errors++;
      end
      if (p !== e.pres) begin
        $error("pressure_pa expected %0d actual %0d", e.pres, p);
        errors++;
      end
      if (d !== e.derr) begin
        $error("divide_error expected %0b actual %0b", e.derr, d);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 79;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int IDX_W = bpc_pkg::IdxW;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [15:0] in_raw_temperature;
  logic [23:0] in_raw_pressure_word;
  logic out_valid, out_stall;
  logic signed [15:0] out_temperature_deci_c;
  logic [31:0] out_pressure_pa;
  logic out_divide_error;
  logic cfg_we;
  logic [bpc_pkg::IdxW-1:0] cfg_index;
  logic [bpc_pkg::CalW-1:0] cfg_data;

  comp_scoreboard sb;
  bit quiet_tail;
  bit long_hold;
  int idle_count;

  barometric_pressure_compensation_top DUT (.*);

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // send one item, with a random gap before it unless quiet
  // valid stays high afterwards so items can follow back to back
  task automatic send_item(logic [15:0] ut, logic [23:0] up);
    cfg_we <= 0;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1;
    in_raw_temperature <= ut;
    in_raw_pressure_word <= up;
    do @(posedge clk); while (in_stall);
    sb.note_input(ut, up);
    @(negedge clk);
  endtask

  // write enable stays high until the next item or drain
  task automatic write_cfg(logic [bpc_pkg::IdxW-1:0] idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(int'(idx), v);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    cfg_we <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // typical calibration with random spread
  task automatic load_typical(logic [1:0] oss);
    write_cfg(bpc_pkg::REG_AC1_AC2,
              {16'(408 + $urandom_range(0, 8000)), 16'(-72 - $urandom_range(0, 300))});
    write_cfg(bpc_pkg::REG_AC3_AC4,
              {16'(-14383 + $urandom_range(0, 500)), 16'(32741 + $urandom_range(0, 900))});
    write_cfg(bpc_pkg::REG_AC5_AC6,
              {16'(32757 - $urandom_range(0, 9000)), 16'(23153 + $urandom_range(0, 900))});
    write_cfg(bpc_pkg::REG_B1_B2,
              {16'(6190 + $urandom_range(0, 200)), 16'(4 + $urandom_range(0, 60))});
    write_cfg(bpc_pkg::REG_MC_MD,
              {16'(-8711 - $urandom_range(0, 500)), 16'(2868 + $urandom_range(0, 300))});
    write_cfg(bpc_pkg::REG_OSS, {30'd0, oss});
  endtask

  task automatic load_random();
    for (int i = 0; i < 5; i++) write_cfg(IDX_W'(i), $urandom());
    write_cfg(bpc_pkg::REG_OSS, $urandom());
  endtask

  // receiver stall bursts, plus one long hold
  initial begin
    int n;
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1;
        repeat (400) @(negedge clk);
        out_stall <= 0;
        long_hold = 0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 13);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
        repeat ($urandom_range(0, 20)) @(negedge clk);
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_temperature_deci_c, out_pressure_pa, out_divide_error);
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_count <= 0;
    else if (sb.pending.size() != 0 || in_valid) begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    sb.clear_cal();
    idle_count = 0;
    quiet_tail = 0;
    long_hold = 0;
    rst_n = 0;
    in_valid = 0;
    in_raw_temperature = 0;
    in_raw_pressure_word = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    repeat (8) @(negedge clk);
    rst_n = 1;

    // reset calibration: zero divisor
    send_item(16'h0000, 24'h000000);
    send_item(16'hffff, 24'hffffff);
    drain();

    // directed: typical coefficients, extremes, each oss
    for (int o = 0; o < 4; o++) begin
      write_cfg(bpc_pkg::REG_AC1_AC2, {16'sd408, -16'sd72});
      write_cfg(bpc_pkg::REG_AC3_AC4, {-16'sd14383, 16'd32741});
      write_cfg(bpc_pkg::REG_AC5_AC6, {16'd32757, 16'd23153});
      write_cfg(bpc_pkg::REG_B1_B2, {16'sd6190, 16'sd4});
      write_cfg(bpc_pkg::REG_MC_MD, {-16'sd8711, 16'sd2868});
      write_cfg(bpc_pkg::REG_OSS, o);
      send_item(16'd27898, 24'd5984000);
      send_item(16'h0000, 24'h000000);
      send_item(16'hffff, 24'hffffff);
      send_item(16'h5555, 24'haaaaaa);
      drain();
    end
    // temperature divisor zero: x1 = 0 with md = 0
    write_cfg(bpc_pkg::REG_AC5_AC6, 32'h0000_0000);
    write_cfg(bpc_pkg::REG_MC_MD, {16'sd100, 16'sd0});
    send_item(16'd1234, 24'd4000000);
    drain();
    // pressure divisor zero: ac4 = 0
    write_cfg(bpc_pkg::REG_MC_MD, {-16'sd8711, 16'sd2868});
    write_cfg(bpc_pkg::REG_AC3_AC4, {-16'sd14383, 16'd0});
    send_item(16'd27898, 24'd5984000);
    drain();
    // index beyond range is ignored, extremes of registers
    write_cfg(3'd7, 32'hffff_ffff);
    write_cfg(3'd6, 32'hffff_ffff);
    for (int i = 0; i < 5; i++) write_cfg(IDX_W'(i), 32'h8000_8000);
    write_cfg(bpc_pkg::REG_OSS, 32'hffff_ffff);
    send_item(16'h8000, 24'h800000);
    send_item(16'h7fff, 24'h7fffff);
    drain();
    for (int i = 0; i < 5; i++) write_cfg(IDX_W'(i), 32'hffff_ffff);
    send_item(16'hffff, 24'hffffff);
    drain();

    // random phases, mostly realistic calibration
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 4 == 3) load_random();
      else load_typical(ph[1:0]);
      if (ph == 2) long_hold = 1;
      if (ph == 7) quiet_tail = 1;
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 9) < 8)
          send_item(16'($urandom_range(20000, 36000)), 24'($urandom_range(4000000, 10000000)));
        else
          send_item(16'($urandom()), 24'($urandom()));
      end
      drain();
    end

    repeat (LATENCY + 20) @(negedge clk);
    $display("checked %0d readings, %0d with divide error, across all oversampling settings",
             sb.checked, sb.div_errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bpc_pkg.sv
rtl/core/bpc_div.sv
rtl/core/bpc_front.sv
rtl/core/bpc_coef.sv
rtl/core/bpc_tail.sv
rtl/core/barometric_pressure_compensation_top.sv
bench/barometric_pressure_compensation_top_test.sv
